// ===== sv/arp_pkg.sv =====
// Shared types and constants for the ARP cache table.
`default_nettype none

package arp_pkg;

    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int TICK_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int DEF_ENTRIES = 16;
    localparam int CQ_DEPTH    = 2;

    localparam logic [TICK_W-1:0] TICK_MAX  = 32'hFFFF_FFFF;
    localparam logic              OP_UPDATE = 1'b0;
    localparam logic              OP_LOOKUP = 1'b1;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [IP_W-1:0]     ip;
        logic [MAC_W-1:0]    mac;
        logic [TICK_W-1:0]   tick;
    } cmd_t;

    typedef struct packed {
        logic [IP_W-1:0]     ip;
        logic [MAC_W-1:0]    mac;
        logic [TICK_W-1:0]   tick;
    } entry_t;

endpackage

`default_nettype wire

// ===== sv/arp_front.sv =====
// Front stage: accept and classify items, hand them to the command queue.
`default_nettype none

module arp_front
    import arp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              opcode,
    input  wire logic [IP_W-1:0]   ip_address,
    input  wire logic [MAC_W-1:0]  mac_address,
    input  wire logic [TICK_W-1:0] now_tick,
    output logic                   q_wr_en,
    output cmd_t                   q_wr_data,
    input  wire logic              q_full
);

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_reg;
    logic accept;
    logic move;

    assign full      = stage_valid_reg && q_full;
    assign move      = stage_valid_reg && !q_full;
    assign accept    = push && !full;
    assign q_wr_en   = move;
    assign q_wr_data = stage_reg;

    always_comb
    begin
        stage_valid_next = accept || (stage_valid_reg && !move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Decode the opcode into a command kind while capturing the item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.kind <= (opcode == OP_LOOKUP) ? CMD_LOOKUP : CMD_UPDATE;
            stage_reg.ip   <= ip_address;
            stage_reg.mac  <= mac_address;
            stage_reg.tick <= now_tick;
        end
    end

endmodule

`default_nettype wire

// ===== sv/arp_cmd_queue.sv =====
// Short command queue between the front stage and the table engine.
`default_nettype none

module arp_cmd_queue
    import arp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      q_full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      q_empty
);

    localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;

    cmd_t            slots_reg [CQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = (count_reg == (PW+1)'(CQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CQ_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CQ_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/arp_engine.sv =====
// Table engine: scans the entry store, applies updates, holds the result.
`default_nettype none

module arp_engine
    import arp_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire cmd_t              q_rd_data,
    output logic                   q_rd_en,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   found,
    output logic [MAC_W-1:0]       found_mac,
    output logic [SLOT_W-1:0]      slot_used
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Entry store, no reset; valid bits gate the match and free checks.
    entry_t          mem [ENTRIES];
    entry_t          mem_q_reg;
    logic            v_q_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    cmd_t            cmd_reg;
    logic [IW:0]     iss_reg;
    logic [IW:0]     iss_next;
    logic            rd_v_reg;
    logic            rd_v_next;
    logic [IW-1:0]   rd_idx_reg;
    logic [IW-1:0]   rd_idx_next;

    logic              hit_reg,      hit_next;
    logic [IW-1:0]     hit_idx_reg,  hit_idx_next;
    logic [MAC_W-1:0]  hit_mac_reg,  hit_mac_next;
    logic              free_reg,     free_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic [TICK_W-1:0] old_tick_reg, old_tick_next;
    logic [IW-1:0]     old_idx_reg,  old_idx_next;

    logic              res_valid_reg, res_valid_next;
    logic              res_found_reg;
    logic [MAC_W-1:0]  res_mac_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    logic              start;
    logic              issue;
    logic              finish;
    logic [IW-1:0]     raddr;
    logic              we;
    logic [IW-1:0]     widx;
    logic              d_found;
    logic [MAC_W-1:0]  d_mac;
    logic [IW-1:0]     d_idx;
    logic [7:0]        d_idx_wide;

    assign empty     = !res_valid_reg;
    assign found     = res_found_reg;
    assign found_mac = res_mac_reg;
    assign slot_used = res_slot_reg;

    assign start   = (state_reg == S_IDLE) && !q_empty && !res_valid_reg;
    assign q_rd_en = start;
    assign issue   = (state_reg == S_SCAN) && (iss_reg != (IW+1)'(ENTRIES));
    assign raddr   = iss_reg[IW-1:0];
    assign finish  = (state_reg == S_DONE);

    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        rd_v_next   = issue;
        rd_idx_next = raddr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    iss_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (rd_v_reg && (rd_idx_reg == IW'(ENTRIES-1)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Fold one entry per cycle into the match, free and oldest trackers.
    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_mac_next  = hit_mac_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        old_tick_next = old_tick_reg;
        old_idx_next  = old_idx_reg;
        if (start)
        begin
            hit_next      = 1'b0;
            hit_idx_next  = '0;
            hit_mac_next  = '0;
            free_next     = 1'b0;
            free_idx_next = '0;
            old_tick_next = TICK_MAX;
            old_idx_next  = '0;
        end
        else if (rd_v_reg)
        begin
            if (v_q_reg && (mem_q_reg.ip == cmd_reg.ip) && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
                hit_mac_next = mem_q_reg.mac;
            end
            if (!v_q_reg && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            if (mem_q_reg.tick < old_tick_reg)
            begin
                old_tick_next = mem_q_reg.tick;
                old_idx_next  = rd_idx_reg;
            end
        end
    end

    // Resolve the finished scan into a write-back and a result.
    always_comb
    begin
        we      = 1'b0;
        widx    = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);
        d_found = hit_reg;
        d_mac   = '0;
        d_idx   = '0;
        unique case (cmd_reg.kind)
            CMD_UPDATE:
            begin
                we    = finish;
                d_idx = widx;
            end
            CMD_LOOKUP:
            begin
                if (hit_reg)
                begin
                    d_mac = hit_mac_reg;
                    d_idx = hit_idx_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        d_idx_wide = 8'(d_idx);
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_reg       <= '0;
            rd_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            rd_v_reg      <= rd_v_next;
            res_valid_reg <= res_valid_next;
            if (we)
            begin
                valid_reg[widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_mac_reg  <= hit_mac_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        old_tick_reg <= old_tick_next;
        old_idx_reg  <= old_idx_next;
        if (start)
        begin
            cmd_reg <= q_rd_data;
        end
        if (finish)
        begin
            res_found_reg <= d_found;
            res_mac_reg   <= d_mac;
            res_slot_reg  <= d_idx_wide[SLOT_W-1:0];
        end
    end

    // Entry store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[widx] <= '{ip: cmd_reg.ip, mac: cmd_reg.mac, tick: cmd_reg.tick};
        end
        mem_q_reg <= mem[raddr];
        v_q_reg   <= valid_reg[raddr];
    end

    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> res_valid_reg)
        else $error("finished scan did not load the result register");

    a_no_start_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !res_valid_reg)
        else $error("engine busy while a result is still waiting");

    a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cmd_reg.kind == CMD_UPDATE) |=> valid_reg[$past(widx)])
        else $error("updated entry not marked valid");

    a_miss_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_found_reg) |-> (res_mac_reg == '0))
        else $error("miss result carries a nonzero MAC");

    a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) >= $past($countones(valid_reg))))
        else $error("an entry lost its valid bit");

endmodule

`default_nettype wire

// ===== sv/arp_cache_table.sv =====
// ARP cache table top level: front stage, command queue and table engine.
//
// Fully associative IPv4-to-MAC cache of ENTRIES entries. Push update
// (opcode 0) or lookup (opcode 1) items; each gives exactly one result item,
// in order. An update refreshes a matching entry or claims the first free
// entry, else the entry with the smallest stored tick (lowest index on ties).
// In the engine each item takes a start step, then a scan of one entry per
// cycle through the single read port of the entry store, a step to drain the
// read and a step to write back and post the result. A two-deep command
// queue plus an input stage keep accepting items while the engine is busy
// or a result waits to be popped. Valid bits clear at reset, so there is
// no clearing pass.
`default_nettype none

module arp_cache_table
    import arp_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              opcode,
    input  wire logic [IP_W-1:0]   ip_address,
    input  wire logic [MAC_W-1:0]  mac_address,
    input  wire logic [TICK_W-1:0] now_tick,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   found,
    output logic [MAC_W-1:0]       found_mac,
    output logic [SLOT_W-1:0]      slot_used
);

    logic q_wr_en;
    cmd_t q_wr_data;
    logic q_full;
    logic q_rd_en;
    cmd_t q_rd_data;
    logic q_empty;

    arp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .now_tick    (now_tick),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data),
        .q_full      (q_full)
    );

    arp_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    arp_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .empty     (empty),
        .pop       (pop),
        .found     (found),
        .found_mac (found_mac),
        .slot_used (slot_used)
    );

endmodule

`default_nettype wire
